// ===== hw/rtl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the software timer bank
// Operation and timer state codes, default sizes, field widths and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package stb_pkg;

	localparam int DEF_NUM_PLAIN   = 16;
	localparam int DEF_NUM_MANAGED = 16;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int TICK_W  = 16;
	localparam int VALUE_W = 32;
	localparam int STATE_W = 2;

	localparam int IN_BITS   = OP_W + IDX_W + TICK_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = VALUE_W + STATE_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_TICK         = 3'd0,
		OP_READ_PLAIN   = 3'd1,
		OP_CLEAR_PLAIN  = 3'd2,
		OP_READ_MANAGED = 3'd3,
		OP_STOP         = 3'd4,
		OP_START        = 3'd5,
		OP_PAUSE        = 3'd6,
		OP_CONTINUE     = 3'd7
	} op_t;

	typedef enum logic [STATE_W-1:0] {
		TMR_STOPPED = 2'd0,
		TMR_RUNNING = 2'd1,
		TMR_PAUSED  = 2'd2
	} tmr_state_t;

	typedef struct packed {
		logic clear_we;   // clearing pass writes zero at the sweep counter
		logic cnt_clr;    // restart the sweep counter
		logic cnt_inc;    // advance the sweep counter
		logic load_item;  // capture the incoming item
		logic sweep_rd;   // tick sweep reads at the sweep counter
		logic exec;       // finish the held item and load the result register
	} stb_cmd_t;

	typedef struct packed {
		logic cnt_last;   // sweep counter is on the last entry
		logic item_sweep; // incoming item is a tick with a nonzero count
		logic out_free;   // result register can take a new item
	} stb_status_t;

endpackage

// ===== hw/rtl/stb_ram.sv =====
// ----------------------------------------------------------------------------
// stb_ram: generic simple dual-port RAM
// One write port and one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module stb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/stb_ctrl.sv =====
// ----------------------------------------------------------------------------
// stb_ctrl: sequencing of the software timer bank
// Runs the clearing pass after reset, takes one item at a time and steps it
// through a single access or a sweep over all timers.
// ----------------------------------------------------------------------------
module stb_ctrl
	import stb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output stb_cmd_t    cmd,
	input  stb_status_t status
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN,
		ST_EXEC
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic        ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (status.cnt_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= status.item_sweep ? ST_SWEEP : ST_READ;
						ready_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_SWEEP: begin
					if (status.cnt_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_we = 1'b1;
				cmd.cnt_inc  = 1'b1;
			end
			ST_IDLE: begin
				cmd.load_item = s_tvalid;
				cmd.cnt_clr   = s_tvalid;
			end
			ST_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				cmd.cnt_inc  = 1'b1;
			end
			ST_EXEC: begin
				cmd.exec = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign s_tready = ready_q;

endmodule

// ===== hw/rtl/stb_dp.sv =====
// ----------------------------------------------------------------------------
// stb_dp: datapath of the software timer bank
// Holds the item, the two counter memories, the sweep pipeline and the
// result register.
// ----------------------------------------------------------------------------
module stb_dp
	import stb_pkg::*;
#(
	parameter int NUM_PLAIN   = DEF_NUM_PLAIN,
	parameter int NUM_MANAGED = DEF_NUM_MANAGED,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  stb_cmd_t              cmd,
	output stb_status_t           status
);

	localparam int SWEEP_LEN = (NUM_PLAIN > NUM_MANAGED) ? NUM_PLAIN : NUM_MANAGED;
	localparam int SW        = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
	localparam int PAW       = (NUM_PLAIN > 1) ? $clog2(NUM_PLAIN) : 1;
	localparam int MAW       = (NUM_MANAGED > 1) ? $clog2(NUM_MANAGED) : 1;
	localparam int MWORD     = COUNT_WIDTH + STATE_W;
	localparam logic [8:0]    NP9      = 9'(NUM_PLAIN);
	localparam logic [8:0]    NM9      = 9'(NUM_MANAGED);
	localparam logic [SW-1:0] CNT_LAST = SW'(SWEEP_LEN - 1);

	// Incoming item fields.
	op_t               in_op;
	logic [TICK_W-1:0] in_ticks;

	// Held item.
	op_t               op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TICK_W-1:0] ticks_q;

	// Sweep counter and write-back stage.
	logic [SW-1:0] cnt_q;
	logic          sweep_v_s1;
	logic [SW-1:0] sweep_idx_s1;

	// Result register.
	logic               out_v_q;
	logic [VALUE_W-1:0] out_count_q;
	tmr_state_t         out_state_q;

	logic                   cnt_in_p, cnt_in_m, s1_in_p, s1_in_m, idx_in_p, idx_in_m;
	logic                   p_we, m_we;
	logic [PAW-1:0]         p_waddr, p_raddr;
	logic [MAW-1:0]         m_waddr, m_raddr;
	logic [COUNT_WIDTH-1:0] p_wdata, p_rdata;
	logic [MWORD-1:0]       m_wdata, m_rdata;
	logic [COUNT_WIDTH-1:0] m_count, ticks_ext;
	tmr_state_t             m_state, new_state;
	logic [COUNT_WIDTH-1:0] new_count;
	logic                   m_exec_we;
	logic [VALUE_W-1:0]     res_count;
	tmr_state_t             res_state;

	assign in_op    = op_t'(s_tdata[OP_W-1:0]);
	assign in_ticks = s_tdata[OP_W+IDX_W +: TICK_W];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q    <= in_op;
			idx_q   <= s_tdata[OP_W +: IDX_W];
			ticks_q <= in_ticks;
		end
		sweep_idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sweep_v_s1 <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			sweep_v_s1 <= cmd.sweep_rd;
		end
	end

	assign cnt_in_p = 9'(cnt_q) < NP9;
	assign cnt_in_m = 9'(cnt_q) < NM9;
	assign s1_in_p  = 9'(sweep_idx_s1) < NP9;
	assign s1_in_m  = 9'(sweep_idx_s1) < NM9;
	assign idx_in_p = {5'd0, idx_q} < NP9;
	assign idx_in_m = {5'd0, idx_q} < NM9;

	assign ticks_ext = COUNT_WIDTH'(ticks_q);
	assign m_count   = m_rdata[COUNT_WIDTH-1:0];
	assign m_state   = tmr_state_t'(m_rdata[MWORD-1:COUNT_WIDTH]);

	// Read addresses: the sweep counter during a tick sweep, else the held index.
	always_comb begin
		if (cmd.sweep_rd) begin
			p_raddr = cnt_in_p ? PAW'(cnt_q) : '0;
			m_raddr = cnt_in_m ? MAW'(cnt_q) : '0;
		end else begin
			p_raddr = idx_in_p ? PAW'(idx_q) : '0;
			m_raddr = idx_in_m ? MAW'(idx_q) : '0;
		end
	end

	// Outcome of a single-timer item.
	always_comb begin
		new_state = m_state;
		new_count = m_count;
		m_exec_we = 1'b0;
		res_count = '0;
		res_state = TMR_STOPPED;
		case (op_q)
			OP_TICK: begin
				res_count = '0;
			end
			OP_READ_PLAIN: begin
				if (idx_in_p) begin
					res_count = VALUE_W'(p_rdata);
				end
			end
			OP_CLEAR_PLAIN: begin
				res_count = '0;
			end
			default: begin
				if (idx_in_m) begin
					m_exec_we = 1'b1;
					case (op_q)
						OP_READ_MANAGED: res_count = VALUE_W'(m_count);
						OP_STOP:         new_state = TMR_STOPPED;
						OP_START: begin
							if (m_state == TMR_STOPPED) begin
								new_state = TMR_RUNNING;
								new_count = '0;
							end
						end
						OP_PAUSE: begin
							if (m_state == TMR_RUNNING) begin
								new_state = TMR_PAUSED;
							end
						end
						default: begin
							if (m_state == TMR_PAUSED) begin
								new_state = TMR_RUNNING;
							end
						end
					endcase
					res_state = new_state;
				end
			end
		endcase
	end

	// Write ports: clearing pass, sweep write-back or single-timer update.
	always_comb begin
		if (cmd.clear_we) begin
			p_we    = cnt_in_p;
			p_waddr = PAW'(cnt_q);
			p_wdata = '0;
			m_we    = cnt_in_m;
			m_waddr = MAW'(cnt_q);
			m_wdata = '0;
		end else if (sweep_v_s1) begin
			p_we    = s1_in_p;
			p_waddr = PAW'(sweep_idx_s1);
			p_wdata = p_rdata + ticks_ext;
			m_we    = s1_in_m && (m_state == TMR_RUNNING);
			m_waddr = MAW'(sweep_idx_s1);
			m_wdata = {TMR_RUNNING, m_count + ticks_ext};
		end else begin
			p_we    = cmd.exec && (op_q == OP_CLEAR_PLAIN) && idx_in_p;
			p_waddr = PAW'(idx_q);
			p_wdata = '0;
			m_we    = cmd.exec && m_exec_we;
			m_waddr = MAW'(idx_q);
			m_wdata = {new_state, new_count};
		end
	end

	stb_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_PLAIN),
		.AW    (PAW)
	) u_plain_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	stb_ram #(
		.WIDTH (MWORD),
		.DEPTH (NUM_MANAGED),
		.AW    (MAW)
	) u_managed_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.exec) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_count_q <= res_count;
			out_state_q <= res_state;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_state_q, out_count_q};

	assign status.cnt_last   = (cnt_q == CNT_LAST);
	assign status.item_sweep = (in_op == OP_TICK) && (in_ticks != '0);
	assign status.out_free   = !out_v_q || m_tready;

endmodule

// ===== hw/rtl/software_timer_bank.sv =====
// ----------------------------------------------------------------------------
// software_timer_bank: plain and managed elapsed-time counter banks
// Top level joining the sequencing controller and the counter datapath.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_ channel and each one gives exactly one item on the m_
// channel. An item carries an operation, a timer index and a tick count. A
// tick with a nonzero count adds the count to every plain timer and to every
// running managed timer; the other operations read, clear or command a single
// timer. Results carry the read count (zero for non-reads) and the state of the
// addressed managed timer (stopped for ticks and plain-timer operations).
// The block works on one item at a time. A single-timer item passes a memory
// read step and an update step that loads the result register. A nonzero
// tick walks all timers, one per cycle, through the read port of each counter
// memory with write-back in the following cycle, then takes a drain step and
// the update step. s_tready rises at the edge that loads the result, so the
// next item can be accepted in the cycle after that edge.
// After reset the block clears both memories, one entry per cycle, with
// s_tready low.
// A result waits in its output register while the receiver stalls; the next
// item is still accepted and runs up to its update step, where it holds until
// the output register is free.
// ----------------------------------------------------------------------------
module software_timer_bank
	import stb_pkg::*;
#(
	parameter int NUM_PLAIN   = DEF_NUM_PLAIN,
	parameter int NUM_MANAGED = DEF_NUM_MANAGED,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata, from bit 0: operation[2:0], timer_index[6:3], tick_count[22:7],
	// zero fill[23].
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata, from bit 0: count_value[31:0], timer_state[33:32],
	// zero fill[39:34].
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// Commands from the controller and status back from the datapath.
	stb_cmd_t    cmd;
	stb_status_t status;

	stb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// The datapath captures the item only when the controller accepts it.
	stb_dp #(
		.NUM_PLAIN   (NUM_PLAIN),
		.NUM_MANAGED (NUM_MANAGED),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

// ===== hw/rtl/stb_checker.sv =====
// ----------------------------------------------------------------------------
// stb_checker: port-level checks of the software timer bank
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module stb_checker
	import stb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in work");

	// The reported state is never the unused code.
	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3)
		else $error("invalid timer state reported");

	// The fill bits above the result fields stay zero.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
		else $error("nonzero fill bits in result");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/software_timer_bank_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// software_timer_bank_tb: self-checking bench for the software timer bank
// Feeds directed and random operations through the s_ stream and predicts
// every result with an independent model of both counter banks. Results taken
// from the m_ stream are checked field by field in order. Both sides idle at
// random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module software_timer_bank_tb;
	import stb_pkg::*;

	localparam int NPLAIN      = DEF_NUM_PLAIN;
	localparam int NMANAGED    = DEF_NUM_MANAGED;
	localparam int SWEEP_CYC   = (NPLAIN > NMANAGED ? NPLAIN : NMANAGED) + 3;
	localparam int DRAIN_CYC   = 4 * SWEEP_CYC;
	localparam int RANDOM_ITEMS = 900;
	localparam int STALL_AT     = 300;   // results seen before the long stall
	localparam int STALL_CYC    = 200;
	localparam int QUIET_FROM   = 2000;  // cycle window with no idling at all
	localparam int QUIET_TO     = 4000;
	localparam int IDLE_PCT     = 18;
	localparam int WATCHDOG_CYC = 4000;

	typedef struct {
		op_t         op;
		logic [3:0]  idx;
		logic [15:0] ticks;
	} timer_cmd_t;

	typedef struct {
		logic [31:0] value;
		tmr_state_t  st;
	} timer_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// s_tdata, from bit 0: operation[2:0], timer_index[6:3], tick_count[22:7],
	// zero fill[23].
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// m_tdata, from bit 0: count_value[31:0], timer_state[33:32],
	// zero fill[39:34].
	logic [OUT_DATA_W-1:0] m_tdata;

	software_timer_bank u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands still to be sent, and results owed by the block, oldest first.
	timer_cmd_t    cmd_q[$];
	timer_result_t result_q[$];
	timer_cmd_t    cmd_on_bus;
	timer_result_t want;

	// Predicted contents of both banks. The bench starts from the reset state.
	logic [31:0] plain_cnt[NPLAIN];
	logic [31:0] mgd_cnt[NMANAGED];
	tmr_state_t  mgd_st[NMANAGED];

	int fail_cnt = 0;
	int results_seen = 0;
	int cyc = 0;
	int stall_left = 0;
	bit stall_done = 1'b0;
	int watchdog = 0;

	function automatic bit quiet_window();
		return cyc >= QUIET_FROM && cyc < QUIET_TO;
	endfunction

	function automatic bit idle_now();
		return !quiet_window() && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// Applies one command to the predicted banks and returns the result that
	// the block owes for it. The index field cannot address beyond a bank of
	// sixteen, so no out-of-range case is reachable at these sizes.
	function automatic timer_result_t timer_bank_apply(input timer_cmd_t c);
		timer_result_t r;
		tmr_state_t    st;
		r.value = '0;
		r.st    = TMR_STOPPED;
		case (c.op)
			OP_TICK: begin
				if (c.ticks != '0) begin
					for (int i = 0; i < NPLAIN; i++)
						plain_cnt[i] = plain_cnt[i] + 32'(c.ticks);
					for (int i = 0; i < NMANAGED; i++)
						if (mgd_st[i] == TMR_RUNNING)
							mgd_cnt[i] = mgd_cnt[i] + 32'(c.ticks);
				end
			end
			OP_READ_PLAIN: r.value = plain_cnt[c.idx];
			OP_CLEAR_PLAIN: plain_cnt[c.idx] = '0;
			default: begin
				st = mgd_st[c.idx];
				case (c.op)
					OP_READ_MANAGED: r.value = mgd_cnt[c.idx];
					OP_STOP: st = TMR_STOPPED;
					OP_START: begin
						// Only a stopped timer restarts from zero.
						if (st == TMR_STOPPED) begin
							mgd_cnt[c.idx] = '0;
							st = TMR_RUNNING;
						end
					end
					OP_PAUSE: if (st == TMR_RUNNING) st = TMR_PAUSED;
					OP_CONTINUE: if (st == TMR_PAUSED) st = TMR_RUNNING;
					default: ;
				endcase
				mgd_st[c.idx] = st;
				r.st = st;
			end
		endcase
		return r;
	endfunction

	function automatic logic [15:0] rand_ticks();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 16'h0000;
		if (pick == 1)
			return 16'hFFFF;
		if (pick < 5)
			return 16'($urandom_range(1, 15));
		return 16'($urandom_range(1, 65535));
	endfunction

	task automatic queue_cmd(input op_t op, input int idx, input logic [15:0] ticks);
		timer_cmd_t c;
		c.op    = op;
		c.idx   = 4'(idx);
		c.ticks = ticks;
		cmd_q.push_back(c);
	endtask

	// A managed timer walked through its whole life with random tick counts.
	// Now and then a step is dropped so that commands hit the wrong state.
	task automatic queue_lifecycle();
		int idx;
		idx = $urandom_range(0, NMANAGED - 1);
		queue_cmd(OP_START, idx, 16'($urandom));
		repeat ($urandom_range(1, 3))
			queue_cmd(OP_TICK, $urandom_range(0, 15), rand_ticks());
		queue_cmd(OP_READ_MANAGED, idx, 16'($urandom));
		if ($urandom_range(0, 3) != 0)
			queue_cmd(OP_PAUSE, idx, 16'($urandom));
		queue_cmd(OP_TICK, $urandom_range(0, 15), rand_ticks());
		queue_cmd(OP_READ_MANAGED, idx, 16'($urandom));
		if ($urandom_range(0, 3) != 0)
			queue_cmd(OP_CONTINUE, idx, 16'($urandom));
		queue_cmd(OP_TICK, $urandom_range(0, 15), rand_ticks());
		queue_cmd(OP_READ_PLAIN, $urandom_range(0, NPLAIN - 1), 16'($urandom));
		if ($urandom_range(0, 4) != 0)
			queue_cmd(OP_STOP, idx, 16'($urandom));
		queue_cmd(OP_READ_MANAGED, idx, 16'($urandom));
	endtask

	// Sender: offers the next queued command when the bus is free and it is not
	// idling. A command on the bus is held until the block takes it, and is
	// applied to the predicted banks at that edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				result_q.push_back(timer_bank_apply(cmd_on_bus));
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && !idle_now()) begin
					cmd_on_bus = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}},
						cmd_on_bus.ticks, cmd_on_bus.idx, cmd_on_bus.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver readiness: random idling, plus one long hold-off once enough
	// results have come, so the result register fills and s_tready drops.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cyc <= cyc + 1;
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (!stall_done && results_seen >= STALL_AT) begin
				stall_done <= 1'b1;
				stall_left <= STALL_CYC;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !idle_now();
			end
		end
	end

	// Result checker: each result taken is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (result_q.size() == 0) begin
				$display("%0t: result with no command pending: count %h state %0d",
					$time, m_tdata[31:0], m_tdata[33:32]);
				fail_cnt++;
			end else begin
				want = result_q.pop_front();
				if (m_tdata[31:0] !== want.value) begin
					$display("%0t: count_value expected %h actual %h",
						$time, want.value, m_tdata[31:0]);
					fail_cnt++;
				end
				if (m_tdata[33:32] !== want.st) begin
					$display("%0t: timer_state expected %0d actual %0d",
						$time, want.st, m_tdata[33:32]);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither stream moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_CYC) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_CYC);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NPLAIN; i++)
			plain_cnt[i] = '0;
		for (int i = 0; i < NMANAGED; i++) begin
			mgd_cnt[i] = '0;
			mgd_st[i]  = TMR_STOPPED;
		end

		// Directed part: fresh reads, commands in the wrong state, zero and
		// full-scale ticks, clear, stop keeping the count, restart clearing it.
		queue_cmd(OP_READ_PLAIN, 0, 16'hFFFF);
		queue_cmd(OP_READ_MANAGED, 15, 16'h0000);
		queue_cmd(OP_PAUSE, 3, 16'h0000);
		queue_cmd(OP_CONTINUE, 3, 16'h0000);
		queue_cmd(OP_START, 3, 16'h0000);
		queue_cmd(OP_START, 3, 16'hFFFF);
		queue_cmd(OP_TICK, 15, 16'h0000);
		queue_cmd(OP_TICK, 0, 16'hFFFF);
		queue_cmd(OP_READ_PLAIN, 15, 16'h0000);
		queue_cmd(OP_READ_MANAGED, 3, 16'h0000);
		queue_cmd(OP_CONTINUE, 3, 16'h0000);
		queue_cmd(OP_PAUSE, 3, 16'h0000);
		queue_cmd(OP_PAUSE, 3, 16'h0000);
		queue_cmd(OP_TICK, 7, 16'h0001);
		queue_cmd(OP_READ_MANAGED, 3, 16'h0000);
		queue_cmd(OP_CONTINUE, 3, 16'h0000);
		queue_cmd(OP_TICK, 10, 16'h5555);
		queue_cmd(OP_CLEAR_PLAIN, 15, 16'hAAAA);
		queue_cmd(OP_READ_PLAIN, 15, 16'h0000);
		queue_cmd(OP_READ_PLAIN, 0, 16'h0000);
		queue_cmd(OP_STOP, 3, 16'h0000);
		queue_cmd(OP_READ_MANAGED, 3, 16'h0000);
		queue_cmd(OP_START, 3, 16'h0000);
		queue_cmd(OP_READ_MANAGED, 3, 16'h0000);
		queue_cmd(OP_STOP, 15, 16'h0000);

		// Random part: mostly timer lifecycles, the rest arbitrary commands.
		while (cmd_q.size() < RANDOM_ITEMS + 25) begin
			if ($urandom_range(0, 99) < 60)
				queue_lifecycle();
			else
				queue_cmd(op_t'($urandom_range(0, 7)), $urandom_range(0, 15),
					$urandom_range(0, 1) ? rand_ticks() : 16'($urandom));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (cmd_q.size() != 0 || s_tvalid || result_q.size() != 0);
		repeat (DRAIN_CYC) @(posedge clk);

		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/stb_pkg.sv
hw/rtl/stb_ram.sv
hw/rtl/stb_ctrl.sv
hw/rtl/stb_dp.sv
hw/rtl/software_timer_bank.sv
hw/rtl/stb_checker.sv
verif/software_timer_bank_tb.sv
